// File: rtl/source_byte_tokenizer_defines.svh
// assertion macros shared by the tokenizer rtl
`ifndef SOURCE_BYTE_TOKENIZER_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_DEFINES_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define SBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbt: assertion failed");

// antecedent implies consequent in the next cycle
`define SBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbt: assertion failed");

`else

`define SBT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBT_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/sbt_pkg.sv
`default_nettype none

package sbt_pkg;

  // sizes
  localparam int LEXEME_LIMIT = 64;
  localparam int LEN_W        = 7;
  localparam int LINE_W       = 24;
  localparam int RES_MAX      = 3;
  localparam int RES_CNT_W    = $clog2(RES_MAX + 1);
  localparam int QUEUE_DEPTH  = 4;
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int FILL_W       = PTR_W + 1;

  localparam logic [LEN_W-1:0]  LEN_LIMIT = LEN_W'(LEXEME_LIMIT);
  localparam logic [LINE_W-1:0] LINE_MAX  = '1;

  // source characters with a special role
  localparam logic [7:0] CH_USCORE = "_";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_BAR    = "|";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_SQUOTE = "'";
  localparam logic [7:0] CH_DQUOTE = "\"";
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [3:0] {
    LM_IDLE, LM_SLASH, LM_COMMENT, LM_IDENT, LM_INT, LM_FLOAT, LM_STRING,
    LM_CHAR_OPEN, LM_CHAR_BODY, LM_COLON, LM_PIPE, LM_MINUS, LM_LT, LM_GT
  } lex_mode_t;

  typedef enum logic [5:0] {
    TK_ERR = 6'd0, TK_IDENT = 6'd1, TK_INT = 6'd2, TK_FLOAT = 6'd3,
    TK_STRING = 6'd4, TK_CHAR = 6'd5, TK_ASSIGN = 6'd6, TK_DCOLON = 6'd7,
    TK_ARROW = 6'd8, TK_COLON = 6'd9, TK_EQ = 6'd10, TK_SEMI = 6'd11,
    TK_COMMA = 6'd12, TK_DOT = 6'd13, TK_LPAR = 6'd14, TK_RPAR = 6'd15,
    TK_LBRACE = 6'd16, TK_RBRACE = 6'd17, TK_LBRACK = 6'd18, TK_RBRACK = 6'd19,
    TK_LPIPE = 6'd20, TK_RPIPE = 6'd21, TK_PLUS = 6'd22, TK_MINUS = 6'd23,
    TK_STAR = 6'd24, TK_SLASH = 6'd25, TK_PCT = 6'd26, TK_AT = 6'd27,
    TK_AMP = 6'd28, TK_BAR = 6'd29, TK_LT = 6'd30, TK_LTE = 6'd31,
    TK_GT = 6'd32, TK_GTE = 6'd33, TK_END = 6'd34
  } tok_code_t;

  typedef enum logic {KIND_BYTE = 1'b0, KIND_RECORD = 1'b1} res_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } sbt_in_t;

  typedef struct packed {
    res_kind_t         kind;
    tok_code_t         token_code;
    logic [7:0]        lexeme_byte;
    logic [LEN_W-1:0]  lex_len;
    logic              truncated;
    logic [LINE_W-1:0] line_number;
    logic              last;
  } sbt_out_t;

  // all results caused by one source byte, slot 0 first
  typedef sbt_out_t [RES_MAX-1:0] res_vec_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0] count;
    res_vec_t             res;
  } sbt_bundle_t;

  // what a byte does when it starts a new token
  typedef struct packed {
    lex_mode_t mode;
    logic      rec_en;
    tok_code_t rec_code;
    logic      byte_en;
    tok_code_t byte_code;
  } begin_t;

  // outcome of a held operator byte against the next byte
  typedef struct packed {
    logic      hit;
    tok_code_t code;
  } pair_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic sbt_out_t mk_res(input res_kind_t kind, input tok_code_t code,
                                      input logic [7:0] b, input logic [LEN_W-1:0] len,
                                      input logic tr, input logic [LINE_W-1:0] line);
    sbt_out_t r;
    r.kind          = kind;
    r.token_code    = code;
    r.lexeme_byte   = b;
    r.lex_len       = len;
    r.truncated     = tr;
    r.line_number   = line;
    r.last          = 1'b0;
    return r;
  endfunction

  // classify a byte that opens a token
  function automatic begin_t begin_info(input logic [7:0] b);
    begin_t bi;
    bi = '{mode: LM_IDLE, rec_en: 1'b0, rec_code: TK_ERR, byte_en: 1'b0, byte_code: TK_ERR};
    if (is_space(b)) begin
      bi.mode = LM_IDLE;
    end else if (is_alpha(b)) begin
      bi.mode      = LM_IDENT;
      bi.byte_en   = 1'b1;
      bi.byte_code = TK_IDENT;
    end else if (is_digit(b)) begin
      bi.mode      = LM_INT;
      bi.byte_en   = 1'b1;
      bi.byte_code = TK_INT;
    end else begin
      bi.rec_en = 1'b1;
      unique case (b)
        CH_DQUOTE: begin bi.mode = LM_STRING;    bi.rec_en = 1'b0; end
        CH_SQUOTE: begin bi.mode = LM_CHAR_OPEN; bi.rec_en = 1'b0; end
        CH_SLASH:  begin bi.mode = LM_SLASH;     bi.rec_en = 1'b0; end
        CH_COLON:  begin bi.mode = LM_COLON;     bi.rec_en = 1'b0; end
        CH_BAR:    begin bi.mode = LM_PIPE;      bi.rec_en = 1'b0; end
        CH_MINUS:  begin bi.mode = LM_MINUS;     bi.rec_en = 1'b0; end
        CH_LT:     begin bi.mode = LM_LT;        bi.rec_en = 1'b0; end
        CH_GT:     begin bi.mode = LM_GT;        bi.rec_en = 1'b0; end
        CH_EQ:     bi.rec_code = TK_EQ;
        ";":       bi.rec_code = TK_SEMI;
        ",":       bi.rec_code = TK_COMMA;
        CH_DOT:    bi.rec_code = TK_DOT;
        "(":       bi.rec_code = TK_LPAR;
        ")":       bi.rec_code = TK_RPAR;
        "{":       bi.rec_code = TK_LBRACE;
        "}":       bi.rec_code = TK_RBRACE;
        "[":       bi.rec_code = TK_LBRACK;
        "]":       bi.rec_code = TK_RBRACK;
        "+":       bi.rec_code = TK_PLUS;
        "*":       bi.rec_code = TK_STAR;
        "%":       bi.rec_code = TK_PCT;
        "@":       bi.rec_code = TK_AT;
        "&":       bi.rec_code = TK_AMP;
        default:   bi.rec_code = TK_ERR;
      endcase
    end
    return bi;
  endfunction

  // pair a held operator byte with the byte after it
  function automatic pair_t pair_lookup(input lex_mode_t mode, input logic [7:0] b);
    pair_t p;
    p = '{hit: 1'b0, code: TK_ERR};
    unique case (mode)
      LM_COLON: begin
        priority if (b == CH_EQ)    p = '{hit: 1'b1, code: TK_ASSIGN};
        else if (b == CH_COLON)     p = '{hit: 1'b1, code: TK_DCOLON};
        else                        p = '{hit: 1'b0, code: TK_COLON};
      end
      LM_PIPE: begin
        if (b == CH_GT) p = '{hit: 1'b1, code: TK_RPIPE};
        else            p = '{hit: 1'b0, code: TK_BAR};
      end
      LM_MINUS: begin
        if (b == CH_GT) p = '{hit: 1'b1, code: TK_ARROW};
        else            p = '{hit: 1'b0, code: TK_MINUS};
      end
      LM_LT: begin
        priority if (b == CH_BAR)   p = '{hit: 1'b1, code: TK_LPIPE};
        else if (b == CH_EQ)        p = '{hit: 1'b1, code: TK_LTE};
        else                        p = '{hit: 1'b0, code: TK_LT};
      end
      LM_GT: begin
        if (b == CH_EQ) p = '{hit: 1'b1, code: TK_GTE};
        else            p = '{hit: 1'b0, code: TK_GT};
      end
      default: p = '{hit: 1'b0, code: TK_ERR};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sbt_lex_core.sv
`default_nettype none

`include "source_byte_tokenizer_defines.svh"

module sbt_lex_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  sbt_pkg::sbt_in_t    in_data,
  output logic                push_valid,
  input  wire                 push_ready,
  output sbt_pkg::sbt_bundle_t push_data
);
  import sbt_pkg::*;

  // input register
  logic    in_v_r;
  sbt_in_t in_r;

  // lexer state
  lex_mode_t         mode_r, mode_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic              cut_r, cut_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [7:0]        chr_r, chr_nxt;

  // per-byte work
  logic [7:0]           b;
  logic                 eoi;
  res_vec_t             res;
  logic [RES_CNT_W-1:0] nres;
  begin_t               bi;
  pair_t                pr;
  pair_t                pf;
  logic                 rec1_en;
  logic                 rec1_lex;
  tok_code_t            rec1_code;
  logic                 do_begin;
  logic                 add_en;
  tok_code_t            add_code;
  logic [7:0]           add_val;
  logic                 char_ok;
  logic                 consume;

  // place a result into the next free slot
  function automatic res_vec_t put(input res_vec_t v, input logic [RES_CNT_W-1:0] i,
                                   input sbt_out_t r);
    res_vec_t o;
    o = v;
    if (i < RES_CNT_W'(RES_MAX)) o[i] = r;
    return o;
  endfunction

  // decode one byte against the current mode
  always_comb begin
    b         = in_r.in_byte;
    eoi       = in_r.end_of_input;
    mode_nxt  = mode_r;
    count_nxt = count_r;
    cut_nxt   = cut_r;
    line_nxt  = line_r;
    chr_nxt   = chr_r;
    res       = '0;
    nres      = '0;
    bi        = begin_info(b);
    pr        = pair_lookup(mode_r, b);
    pf        = '{hit: 1'b0, code: TK_ERR};
    rec1_en   = 1'b0;
    rec1_lex  = 1'b0;
    rec1_code = TK_ERR;
    do_begin  = 1'b0;
    add_en    = 1'b0;
    add_code  = TK_ERR;
    add_val   = b;
    char_ok   = 1'b0;

    unique case (mode_r)
      LM_IDENT: begin
        if (is_alpha(b) || is_digit(b) || (b == CH_USCORE)) begin
          add_en   = 1'b1;
          add_code = TK_IDENT;
        end else begin
          rec1_en   = 1'b1;
          rec1_lex  = 1'b1;
          rec1_code = TK_IDENT;
          do_begin  = 1'b1;
        end
      end
      LM_INT: begin
        priority if (is_digit(b)) begin
          add_en   = 1'b1;
          add_code = TK_INT;
        end else if (b == CH_DOT) begin
          add_en   = 1'b1;
          add_code = TK_FLOAT;
          mode_nxt = LM_FLOAT;
        end else begin
          rec1_en   = 1'b1;
          rec1_lex  = 1'b1;
          rec1_code = TK_INT;
          do_begin  = 1'b1;
        end
      end
      LM_FLOAT: begin
        if (is_digit(b)) begin
          add_en   = 1'b1;
          add_code = TK_FLOAT;
        end else begin
          rec1_en   = 1'b1;
          rec1_lex  = 1'b1;
          rec1_code = TK_FLOAT;
          do_begin  = 1'b1;
        end
      end
      LM_STRING: begin
        if (b == CH_DQUOTE) begin
          rec1_en   = 1'b1;
          rec1_lex  = 1'b1;
          rec1_code = TK_STRING;
          mode_nxt  = LM_IDLE;
        end else begin
          add_en   = 1'b1;
          add_code = TK_STRING;
        end
      end
      LM_CHAR_OPEN: begin
        chr_nxt  = b;
        mode_nxt = LM_CHAR_BODY;
      end
      LM_CHAR_BODY: begin
        if (b == CH_SQUOTE) begin
          count_nxt = '0;
          cut_nxt   = 1'b0;
          add_en    = 1'b1;
          add_code  = TK_CHAR;
          add_val   = chr_r;
          char_ok   = 1'b1;
        end else begin
          rec1_en   = 1'b1;
          rec1_code = TK_ERR;
        end
        chr_nxt  = '0;
        mode_nxt = LM_IDLE;
      end
      LM_SLASH: begin
        if (b == CH_SLASH) begin
          mode_nxt = LM_COMMENT;
        end else begin
          rec1_en   = 1'b1;
          rec1_code = TK_SLASH;
          do_begin  = 1'b1;
        end
      end
      LM_COMMENT: begin
        if (b == CH_LF) mode_nxt = LM_IDLE;
      end
      LM_COLON, LM_PIPE, LM_MINUS, LM_LT, LM_GT: begin
        rec1_en   = 1'b1;
        rec1_code = pr.code;
        if (pr.hit) mode_nxt = LM_IDLE;
        else        do_begin = 1'b1;
      end
      default: do_begin = 1'b1;
    endcase

    // record of the token that this byte closes
    if (rec1_en) begin
      res  = put(res, nres, mk_res(KIND_RECORD, rec1_code, 8'd0,
                                   rec1_lex ? count_nxt : '0,
                                   rec1_lex ? cut_nxt : 1'b0, line_nxt));
      nres = nres + RES_CNT_W'(1);
      if (rec1_lex) begin
        count_nxt = '0;
        cut_nxt   = 1'b0;
      end
    end

    // this byte opens a new token
    if (do_begin) begin
      mode_nxt  = bi.mode;
      count_nxt = '0;
      cut_nxt   = 1'b0;
      if (bi.rec_en) begin
        res  = put(res, nres, mk_res(KIND_RECORD, bi.rec_code, 8'd0, '0, 1'b0, line_nxt));
        nres = nres + RES_CNT_W'(1);
      end
      if (bi.byte_en) begin
        add_en   = 1'b1;
        add_code = bi.byte_code;
      end
    end

    // append a lexeme byte, dropping it past the limit
    if (add_en) begin
      if (count_nxt < LEN_LIMIT) begin
        count_nxt = count_nxt + LEN_W'(1);
        res  = put(res, nres, mk_res(KIND_BYTE, add_code, add_val, count_nxt, 1'b0,
                                     line_nxt));
        nres = nres + RES_CNT_W'(1);
      end else begin
        cut_nxt = 1'b1;
      end
    end

    // closing quote of a char literal
    if (char_ok) begin
      res  = put(res, nres, mk_res(KIND_RECORD, TK_CHAR, 8'd0, count_nxt, cut_nxt,
                                   line_nxt));
      nres = nres + RES_CNT_W'(1);
      count_nxt = '0;
      cut_nxt   = 1'b0;
    end

    // newline count rises after this byte's own results
    if ((b == CH_LF) && (line_nxt != LINE_MAX)) line_nxt = line_nxt + LINE_W'(1);

    // end of source: flush, end record, back to reset state
    if (eoi) begin
      if ((nres == RES_CNT_W'(2)) && ((mode_nxt == LM_IDENT) || (mode_nxt == LM_INT))) begin
        nres      = RES_CNT_W'(1);
        count_nxt = '0;
        cut_nxt   = 1'b1;
      end
      pf = pair_lookup(mode_nxt, 8'd0);
      unique case (mode_nxt)
        LM_IDENT: begin
          res  = put(res, nres, mk_res(KIND_RECORD, TK_IDENT, 8'd0, count_nxt, cut_nxt,
                                       line_nxt));
          nres = nres + RES_CNT_W'(1);
        end
        LM_INT: begin
          res  = put(res, nres, mk_res(KIND_RECORD, TK_INT, 8'd0, count_nxt, cut_nxt,
                                       line_nxt));
          nres = nres + RES_CNT_W'(1);
        end
        LM_FLOAT: begin
          res  = put(res, nres, mk_res(KIND_RECORD, TK_FLOAT, 8'd0, count_nxt, cut_nxt,
                                       line_nxt));
          nres = nres + RES_CNT_W'(1);
        end
        LM_SLASH: begin
          res  = put(res, nres, mk_res(KIND_RECORD, TK_SLASH, 8'd0, '0, 1'b0, line_nxt));
          nres = nres + RES_CNT_W'(1);
        end
        LM_COLON, LM_PIPE, LM_MINUS, LM_LT, LM_GT: begin
          res  = put(res, nres, mk_res(KIND_RECORD, pf.code, 8'd0, '0, 1'b0, line_nxt));
          nres = nres + RES_CNT_W'(1);
        end
        default: ;
      endcase
      res  = put(res, nres, mk_res(KIND_RECORD, TK_END, 8'd0, '0, 1'b0, line_nxt));
      nres = nres + RES_CNT_W'(1);
      mode_nxt  = LM_IDLE;
      count_nxt = '0;
      cut_nxt   = 1'b0;
      line_nxt  = '0;
      chr_nxt   = '0;
    end

    // mark the final result of this byte
    if (nres != '0) res[nres - RES_CNT_W'(1)].last = 1'b1;
  end

  // handshake toward the result queue
  assign consume        = in_v_r && ((nres == '0) || push_ready);
  assign in_ready       = !in_v_r || consume;
  assign push_valid     = in_v_r && (nres != '0);
  assign push_data.count = nres;
  assign push_data.res   = res;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
  end

  // lexer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= LM_IDLE;
      count_r <= '0;
      cut_r   <= 1'b0;
      line_r  <= '0;
      chr_r   <= '0;
    end else if (consume) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      cut_r   <= cut_nxt;
      line_r  <= line_nxt;
      chr_r   <= chr_nxt;
    end
  end

  `SBT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= LEN_LIMIT)
  `SBT_ASSERT_NXT(a_stall_hold, clk, rst_n, in_v_r && !consume, in_v_r && $stable(in_r))
  `SBT_ASSERT_NXT(a_end_reset, clk, rst_n, consume && in_r.end_of_input,
                  (mode_r == LM_IDLE) && (line_r == '0) && (count_r == '0) && !cut_r)

endmodule

`default_nettype wire

// File: rtl/sbt_out_queue.sv
`default_nettype none

`include "source_byte_tokenizer_defines.svh"

module sbt_out_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  sbt_pkg::sbt_bundle_t push_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output sbt_pkg::sbt_out_t    out_data
);
  import sbt_pkg::*;

  sbt_bundle_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [FILL_W-1:0]    fill_r;
  logic [RES_CNT_W-1:0] idx_r;
  sbt_bundle_t          head;
  logic                 push;
  logic                 take;
  logic                 final_res;
  logic                 pop;

  // queue side
  assign push_ready = (fill_r != FILL_W'(QUEUE_DEPTH));
  assign push       = push_valid && push_ready;

  // serialize the head bundle one result at a time
  assign head      = slot_r[rd_ptr_r];
  assign out_valid = (fill_r != '0);
  assign out_data  = head.res[idx_r];
  assign take      = out_valid && out_ready;
  assign final_res = (idx_r == (head.count - RES_CNT_W'(1)));
  assign pop       = take && final_res;

  // bundle storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  // pointers, fill level and result index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      idx_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop)      fill_r <= fill_r + FILL_W'(1);
      else if (pop && !push) fill_r <= fill_r - FILL_W'(1);
      if (take) idx_r <= final_res ? '0 : idx_r + RES_CNT_W'(1);
    end
  end

  `SBT_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_W'(QUEUE_DEPTH))
  `SBT_ASSERT_IMP(a_head_index, clk, rst_n, out_valid,
                  (head.count != '0) && (idx_r < head.count))
  `SBT_ASSERT_IMP(a_last_flag, clk, rst_n, out_valid, out_data.last == final_res)

endmodule

`default_nettype wire

// File: rtl/source_byte_tokenizer.sv
`default_nettype none

// Streaming source tokenizer. One source byte is accepted per clock while the
// result queue has room; a byte is registered, decoded against the lexer mode
// in the following cycle, and its zero to three results (lexeme bytes and
// token records, the final one flagged last) are written, when there are any,
// as one entry into a four-entry result queue. The output port hands out one
// result per cycle while out_ready is high; the first result of a byte passes
// the input register and a queue slot before it is presented, and the rate is
// set by the output side: a byte that yields two or three results holds its
// queue entry until all of them are taken, and input stalls only when all four
// queue entries are waiting. Operator pairs are resolved by holding the first
// byte in the lexer mode; end_of_input flushes a pending token, sends the end
// record and returns the lexer, line counter included, to reset state.
module source_byte_tokenizer (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  sbt_pkg::sbt_in_t  in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output sbt_pkg::sbt_out_t out_data
);
  import sbt_pkg::*;

  logic        push_valid;
  logic        push_ready;
  sbt_bundle_t push_data;

  // byte decode and lexer state
  sbt_lex_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // result queue and serializer
  sbt_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_source_byte_tokenizer.sv
`default_nettype none

module tb_source_byte_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import sbt_pkg::*;

  localparam int RANDOM_ITEMS = 285;
  localparam int DIR_ROWS     = 25;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  // one source byte plus an optional hand-written expectation
  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
    logic       typed;
    logic [1:0] tn;
    tok_code_t  tcode;
  } stim_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  sbt_in_t   in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sbt_out_t  out_data;

  stim_row_t directed_rows [DIR_ROWS];
  stim_row_t src_items [$];
  sbt_out_t  tokens_due [$];
  int        accept_idx = 0;
  int        err_cnt    = 0;
  int        cycle_cnt  = 0;
  logic      calm;

  // lexer shadow state
  lex_mode_t         lx_mode;
  logic [LEN_W-1:0]  lx_count;
  logic [LINE_W-1:0] lx_line;
  logic [7:0]        lx_chr;
  logic              lx_cut;
  sbt_out_t          lx_res [RES_MAX];
  int                lx_n;

  string op_txt [0:27] = '{":=", "::", "->", "|>", "<|", "<=", ">=", ":", "=", ";", ",",
                           ".", "(", ")", "{", "}", "[", "]", "+", "-", "*", "/", "%",
                           "@", "&", "|", "<", ">"};

  source_byte_tokenizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // a window with no idling on either side
  assign calm = (cycle_cnt >= 400) && (cycle_cnt < 900);

  // character classes
  function automatic logic chr_letter(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic chr_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic chr_blank(input logic [7:0] b);
    return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  // append one result for the current byte, at most three
  function automatic void res_push(input res_kind_t k, input tok_code_t c, input logic [7:0] b,
                                   input logic [LEN_W-1:0] len, input logic tr);
    if (lx_n >= RES_MAX) return;
    lx_res[lx_n] = '{kind: k, token_code: c, lexeme_byte: b, lex_len: len,
                     truncated: tr, line_number: lx_line, last: 1'b0};
    lx_n++;
  endfunction

  function automatic void mark(input tok_code_t c);
    res_push(KIND_RECORD, c, 8'd0, '0, 1'b0);
  endfunction

  function automatic void close_lexeme(input tok_code_t c);
    res_push(KIND_RECORD, c, 8'd0, lx_count, lx_cut);
    lx_count = '0;
    lx_cut   = 1'b0;
  endfunction

  // keep a lexeme byte unless the limit is reached
  function automatic void keep_byte(input tok_code_t c, input logic [7:0] b);
    if (lx_count < LEN_LIMIT) begin
      lx_count++;
      res_push(KIND_BYTE, c, b, lx_count, 1'b0);
    end else begin
      lx_cut = 1'b1;
    end
  endfunction

  // byte seen between tokens
  function automatic void start_token(input logic [7:0] b);
    lx_mode  = LM_IDLE;
    lx_count = '0;
    lx_cut   = 1'b0;
    if (chr_blank(b)) return;
    if (chr_letter(b)) begin
      lx_mode = LM_IDENT;
      keep_byte(TK_IDENT, b);
      return;
    end
    if (chr_digit(b)) begin
      lx_mode = LM_INT;
      keep_byte(TK_INT, b);
      return;
    end
    case (b)
      CH_DQUOTE: lx_mode = LM_STRING;
      CH_SQUOTE: lx_mode = LM_CHAR_OPEN;
      CH_SLASH:  lx_mode = LM_SLASH;
      CH_COLON:  lx_mode = LM_COLON;
      CH_BAR:    lx_mode = LM_PIPE;
      CH_MINUS:  lx_mode = LM_MINUS;
      CH_LT:     lx_mode = LM_LT;
      CH_GT:     lx_mode = LM_GT;
      CH_EQ:     mark(TK_EQ);
      ";":       mark(TK_SEMI);
      ",":       mark(TK_COMMA);
      CH_DOT:    mark(TK_DOT);
      "(":       mark(TK_LPAR);
      ")":       mark(TK_RPAR);
      "{":       mark(TK_LBRACE);
      "}":       mark(TK_RBRACE);
      "[":       mark(TK_LBRACK);
      "]":       mark(TK_RBRACK);
      "+":       mark(TK_PLUS);
      "*":       mark(TK_STAR);
      "%":       mark(TK_PCT);
      "@":       mark(TK_AT);
      "&":       mark(TK_AMP);
      default:   mark(TK_ERR);
    endcase
  endfunction

  // held operator byte against the next one
  function automatic void held_op(input logic [7:0] b, input logic [7:0] s1, input tok_code_t c1,
                                  input logic [7:0] s2, input tok_code_t c2,
                                  input tok_code_t alone);
    if (b == s1) begin
      mark(c1);
      lx_mode = LM_IDLE;
    end else if ((s2 != 8'd0) && (b == s2)) begin
      mark(c2);
      lx_mode = LM_IDLE;
    end else begin
      mark(alone);
      start_token(b);
    end
  endfunction

  function automatic void lex_byte(input logic [7:0] b);
    case (lx_mode)
      LM_IDENT: begin
        if (chr_letter(b) || chr_digit(b) || (b == CH_USCORE)) keep_byte(TK_IDENT, b);
        else begin
          close_lexeme(TK_IDENT);
          start_token(b);
        end
      end
      LM_INT: begin
        if (chr_digit(b)) keep_byte(TK_INT, b);
        else if (b == CH_DOT) begin
          keep_byte(TK_FLOAT, b);
          lx_mode = LM_FLOAT;
        end else begin
          close_lexeme(TK_INT);
          start_token(b);
        end
      end
      LM_FLOAT: begin
        if (chr_digit(b)) keep_byte(TK_FLOAT, b);
        else begin
          close_lexeme(TK_FLOAT);
          start_token(b);
        end
      end
      LM_STRING: begin
        if (b == CH_DQUOTE) begin
          close_lexeme(TK_STRING);
          lx_mode = LM_IDLE;
        end else begin
          keep_byte(TK_STRING, b);
        end
      end
      LM_CHAR_OPEN: begin
        lx_chr  = b;
        lx_mode = LM_CHAR_BODY;
      end
      LM_CHAR_BODY: begin
        if (b == CH_SQUOTE) begin
          lx_count = '0;
          lx_cut   = 1'b0;
          keep_byte(TK_CHAR, lx_chr);
          close_lexeme(TK_CHAR);
        end else begin
          mark(TK_ERR);
        end
        lx_chr  = 8'd0;
        lx_mode = LM_IDLE;
      end
      LM_SLASH: begin
        if (b == CH_SLASH) lx_mode = LM_COMMENT;
        else begin
          mark(TK_SLASH);
          start_token(b);
        end
      end
      LM_COMMENT: begin
        if (b == CH_LF) lx_mode = LM_IDLE;
      end
      LM_COLON: held_op(b, CH_EQ, TK_ASSIGN, CH_COLON, TK_DCOLON, TK_COLON);
      LM_PIPE:  held_op(b, CH_GT, TK_RPIPE, 8'd0, TK_ERR, TK_BAR);
      LM_MINUS: held_op(b, CH_GT, TK_ARROW, 8'd0, TK_ERR, TK_MINUS);
      LM_LT:    held_op(b, CH_BAR, TK_LPIPE, CH_EQ, TK_LTE, TK_LT);
      LM_GT:    held_op(b, CH_EQ, TK_GTE, 8'd0, TK_ERR, TK_GT);
      default:  start_token(b);
    endcase
  endfunction

  // pending token at end of source
  function automatic void lex_flush();
    case (lx_mode)
      LM_IDENT: close_lexeme(TK_IDENT);
      LM_INT:   close_lexeme(TK_INT);
      LM_FLOAT: close_lexeme(TK_FLOAT);
      LM_SLASH: mark(TK_SLASH);
      LM_COLON: mark(TK_COLON);
      LM_PIPE:  mark(TK_BAR);
      LM_MINUS: mark(TK_MINUS);
      LM_LT:    mark(TK_LT);
      LM_GT:    mark(TK_GT);
      default:  ;
    endcase
  endfunction

  function automatic void lex_clear();
    lx_mode  = LM_IDLE;
    lx_count = '0;
    lx_line  = '0;
    lx_chr   = 8'd0;
    lx_cut   = 1'b0;
  endfunction

  // all results caused by one source byte
  function automatic void predict_tokens(input sbt_in_t it);
    lx_n = 0;
    lex_byte(it.in_byte);
    if ((it.in_byte == CH_LF) && (lx_line != LINE_MAX)) lx_line++;
    if (it.end_of_input) begin
      // no room for the byte of a token opened by the last byte
      if ((lx_n == 2) && ((lx_mode == LM_IDENT) || (lx_mode == LM_INT))) begin
        lx_n     = 1;
        lx_count = '0;
        lx_cut   = 1'b1;
      end
      lex_flush();
      mark(TK_END);
      lex_clear();
    end
    if (lx_n > 0) lx_res[lx_n-1].last = 1'b1;
  endfunction

  // stimulus generation
  function automatic void push_src(input logic [7:0] b);
    src_items.push_back('{b: b, eoi: 1'b0, typed: 1'b0, tn: 2'd0, tcode: TK_ERR});
  endfunction

  function automatic int lexeme_len();
    return ($urandom_range(0, 29) == 0) ? $urandom_range(62, 70) : $urandom_range(1, 6);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_ident_tail();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return rand_letter();
    if (r < 62) return rand_digit();
    return CH_USCORE;
  endfunction

  function automatic void add_piece();
    int r, n, k;
    logic [7:0] b;
    string s;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      n = lexeme_len();
      push_src(rand_letter());
      for (k = 1; k < n; k++) push_src(rand_ident_tail());
    end else if (r < 32) begin
      n = lexeme_len();
      for (k = 0; k < n; k++) push_src(rand_digit());
    end else if (r < 40) begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) push_src(rand_digit());
      push_src(CH_DOT);
      n = $urandom_range(0, 3);
      for (k = 0; k < n; k++) push_src(rand_digit());
    end else if (r < 50) begin
      n = lexeme_len() - 1;
      push_src(CH_DQUOTE);
      for (k = 0; k < n; k++) begin
        b = 8'($urandom_range(0, 255));
        push_src((b == CH_DQUOTE) ? 8'("s") : b);
      end
      push_src(CH_DQUOTE);
    end else if (r < 58) begin
      push_src(CH_SQUOTE);
      push_src(8'($urandom_range(0, 255)));
      push_src(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : CH_SQUOTE);
    end else if (r < 80) begin
      s = op_txt[$urandom_range(0, 27)];
      for (k = 0; k < s.len(); k++) push_src(s[k]);
    end else if (r < 88) begin
      push_src(CH_SLASH);
      push_src(CH_SLASH);
      n = $urandom_range(0, 5);
      for (k = 0; k < n; k++) begin
        b = 8'($urandom_range(0, 255));
        push_src((b == CH_LF) ? 8'("c") : b);
      end
      push_src(CH_LF);
    end else begin
      push_src(8'($urandom_range(0, 255)));
    end
  endfunction

  // whole sources, each closed by an end marker, some left open at the end
  function automatic void build_random();
    int n, k;
    while (src_items.size() < DIR_ROWS + RANDOM_ITEMS) begin
      n = $urandom_range(1, 12);
      for (k = 0; (k < n) && (src_items.size() < DIR_ROWS + RANDOM_ITEMS); k++) begin
        add_piece();
        case ($urandom_range(0, 7))
          0: push_src(" ");
          1: push_src(8'h09);
          2: push_src(CH_LF);
          3: push_src(8'h0D);
          4: push_src(8'($urandom_range(11, 12)));
          default: ;
        endcase
      end
      case ($urandom_range(0, 7))
        0: push_src(CH_DQUOTE);
        1: push_src(CH_SQUOTE);
        2: begin
          push_src(CH_SLASH);
          push_src(CH_SLASH);
        end
        default: ;
      endcase
      src_items[src_items.size()-1].eoi = 1'b1;
    end
  endfunction

  function automatic void cmp_field(input string fname, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  // cycle count and timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rst_n) out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  // predict on each accepted item
  always @(posedge clk) begin
    sbt_out_t fixed;
    stim_row_t row;
    if (rst_n && in_valid && in_ready) begin
      row = src_items[accept_idx];
      predict_tokens(in_data);
      if (row.typed) begin
        if (row.tn != 2'd0) begin
          fixed = '{kind: KIND_RECORD, token_code: row.tcode, lexeme_byte: 8'd0,
                    lex_len: '0, truncated: 1'b0, line_number: '0, last: 1'b1};
          tokens_due.push_back(fixed);
        end
      end else begin
        for (int i = 0; i < lx_n; i++) tokens_due.push_back(lx_res[i]);
      end
      accept_idx <= accept_idx + 1;
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    sbt_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result: expected none, actual %0h", $time, out_data);
      end else begin
        want = tokens_due.pop_front();
        cmp_field("kind", 32'(want.kind), 32'(out_data.kind));
        cmp_field("token_code", 32'(want.token_code), 32'(out_data.token_code));
        cmp_field("lexeme_byte", 32'(want.lexeme_byte), 32'(out_data.lexeme_byte));
        cmp_field("lex_len", 32'(want.lex_len), 32'(out_data.lex_len));
        cmp_field("truncated", 32'(want.truncated), 32'(out_data.truncated));
        cmp_field("line_number", 32'(want.line_number), 32'(out_data.line_number));
        cmp_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  initial begin
    // directed source: unknown bytes, lone slash, char literals, operator
    // pairs, a float, end of input opening an identifier, open string at end
    directed_rows = '{
      '{8'h00,     1'b0, 1'b1, 2'd1, TK_ERR},
      '{8'hFF,     1'b0, 1'b1, 2'd1, TK_ERR},
      '{CH_USCORE, 1'b0, 1'b1, 2'd1, TK_ERR},
      '{CH_EQ,     1'b0, 1'b1, 2'd1, TK_EQ},
      '{CH_SLASH,  1'b0, 1'b1, 2'd0, TK_ERR},
      '{"a",       1'b0, 1'b0, 2'd0, TK_ERR},
      '{"9",       1'b0, 1'b0, 2'd0, TK_ERR},
      '{CH_COLON,  1'b0, 1'b0, 2'd0, TK_ERR},
      '{CH_EQ,     1'b0, 1'b1, 2'd1, TK_ASSIGN},
      '{CH_SQUOTE, 1'b0, 1'b1, 2'd0, TK_ERR},
      '{8'hFF,     1'b0, 1'b1, 2'd0, TK_ERR},
      '{CH_SQUOTE, 1'b0, 1'b0, 2'd0, TK_ERR},
      '{CH_SQUOTE, 1'b0, 1'b1, 2'd0, TK_ERR},
      '{"x",       1'b0, 1'b1, 2'd0, TK_ERR},
      '{"y",       1'b0, 1'b1, 2'd1, TK_ERR},
      '{CH_LF,     1'b0, 1'b1, 2'd0, TK_ERR},
      '{"1",       1'b0, 1'b0, 2'd0, TK_ERR},
      '{CH_DOT,    1'b0, 1'b0, 2'd0, TK_ERR},
      '{CH_LT,     1'b0, 1'b0, 2'd0, TK_ERR},
      '{"a",       1'b1, 1'b0, 2'd0, TK_ERR},
      '{CH_DQUOTE, 1'b0, 1'b1, 2'd0, TK_ERR},
      '{"q",       1'b0, 1'b0, 2'd0, TK_ERR},
      '{"z",       1'b1, 1'b0, 2'd0, TK_ERR},
      '{CH_MINUS,  1'b1, 1'b0, 2'd0, TK_ERR},
      '{" ",       1'b1, 1'b1, 2'd1, TK_END}
    };
    foreach (directed_rows[i]) src_items.push_back(directed_rows[i]);
    build_random();
    lex_clear();

    // synchronous reset
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender with random gaps
    for (int i = 0; i < src_items.size(); i++) begin
      while (!calm && ($urandom_range(0, 99) < 25)) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= '{in_byte: src_items[i].b, end_of_input: src_items[i].eoi};
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    // drain
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tokens_due.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected results never arrived", $time, tokens_due.size());
    end

    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
